[rtl/sparse_polynomial_merge_add_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for sparse_polynomial_merge_add_top
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SPARSE_POLYNOMIAL_MERGE_ADD_TOP_ASSERT_SVH
`define SPARSE_POLYNOMIAL_MERGE_ADD_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every edge outside reset.
`define SPMA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("spma assertion failed");

// Checked on every edge, reset included.
`define SPMA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("spma assertion failed");

`else

`define SPMA_ASSERT(lbl, clk, rstn, prop)
`define SPMA_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

[rtl/spma_pkg.sv]
// ----------------------------------------------------------------------------
// spma_pkg
// Shared types and codes for the sparse polynomial merge adder.
// ----------------------------------------------------------------------------
package spma_pkg;

  localparam int unsigned OpW      = 2;
  localparam int unsigned InCoeffW = 16;
  localparam int unsigned InExpW   = 16;
  localparam int unsigned OutCoeffW = 17;
  localparam int unsigned OutExpW  = 16;

  localparam logic [OpW-1:0] OP_LOAD_A = 2'd0;
  localparam logic [OpW-1:0] OP_LOAD_B = 2'd1;
  localparam logic [OpW-1:0] OP_MERGE  = 2'd2;

  typedef struct packed {
    logic [OpW-1:0]             opcode;
    logic signed [InCoeffW-1:0] term_coeff;
    logic [InExpW-1:0]          term_exponent;
  } in_item_t;

  typedef struct packed {
    logic signed [OutCoeffW-1:0] sum_coeff;
    logic [OutExpW-1:0]          sum_exponent;
    logic                        from_both;
    logic                        empty_result;
    logic                        dropped_terms;
    logic                        last_term;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_MERGE = 2'b10
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic step;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic last;
  } dp_sts_t;

endpackage

[rtl/sparse_polynomial_merge_add_top.sv]
// ----------------------------------------------------------------------------
// sparse_polynomial_merge_add_top
// Adds two sparse polynomials by merging two term stores.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o, in_data_i): opcode 0 and 1 load one
//   (coefficient, exponent) term into store A or B, highest exponent first.
//   A load into a full store is dropped and reported on the next merge.
//   Opcode 2 starts a merge; opcode 3 is ignored.
//   Output channel (out_valid_o/out_ready_i, out_data_o): a merge returns
//   one transfer per merged term, last_term set on the final one, or a
//   single empty_result transfer when both stores are empty.
//   A merge produces one term per cycle while the output register can take
//   it, and each term passes through that register; the registered RAM read
//   is prefetched from the next index, which keeps the term at the current
//   index ready for every step.
//   No new input is taken until the merge has issued its last term.
//   When the receiver stalls the output register holds and the merge walk
//   pauses. Reset clears both fill counts and the overflow flag; store
//   contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module sparse_polynomial_merge_add_top
  import spma_pkg::*;
#(
  parameter int unsigned MAX_TERMS  = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  spma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (in_data_i.opcode),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  spma_dp #(
    .MAX_TERMS  (MAX_TERMS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[rtl/spma_ram.sv]
// ----------------------------------------------------------------------------
// spma_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spma_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/spma_ctrl.sv]
// ----------------------------------------------------------------------------
// spma_ctrl
// Sequencer: decodes input opcodes and paces the merge walk.
// ----------------------------------------------------------------------------
module spma_ctrl
  import spma_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [OpW-1:0] opcode_i,
  input  dp_sts_t        sts_i,
  output dp_cmd_t        cmd_o
);

  state_e state_q, state_d;
  logic   in_xfer;

  assign in_ready_o = (state_q == ST_IDLE) && sts_i.out_free;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    state_d       = state_q;
    cmd_o.load_a  = 1'b0;
    cmd_o.load_b  = 1'b0;
    cmd_o.step    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          case (opcode_i)
            OP_LOAD_A: cmd_o.load_a = 1'b1;
            OP_LOAD_B: cmd_o.load_b = 1'b1;
            OP_MERGE:  state_d      = ST_MERGE;
            default:   ;  // unused opcode: dropped silently
          endcase
        end
      end
      ST_MERGE: begin
        // one term per cycle whenever the output register can take it
        cmd_o.step = sts_i.out_free;
        if (sts_i.out_free && sts_i.last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/spma_dp.sv]
// ----------------------------------------------------------------------------
// spma_dp
// Term stores, fill counters, merge compare/add and output register.
// ----------------------------------------------------------------------------
`include "sparse_polynomial_merge_add_top_assert.svh"

module spma_dp
  import spma_pkg::*;
#(
  parameter int unsigned MAX_TERMS  = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_data_i,
  input  dp_cmd_t   cmd_i,
  output dp_sts_t   sts_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  // term field widths follow the payload structs
  localparam int unsigned EXP_BITS   = InExpW;
  localparam int unsigned COEFF_BITS = InCoeffW;

  localparam int unsigned AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned CW = $clog2(MAX_TERMS + 1);
  localparam int unsigned TW = COEFF_BITS + EXP_BITS;
  localparam logic [CW-1:0] FullCnt = CW'(MAX_TERMS);

  logic [CW-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CW-1:0] idx_a_q, idx_a_d, idx_b_q, idx_b_d;
  logic [CW-1:0] idx_a_nx, idx_b_nx;
  logic          ovf_q, ovf_d;

  logic          we_a, we_b;
  logic [TW-1:0] wdata, rd_a, rd_b;

  logic signed [COEFF_BITS-1:0] ld_coeff, a_coeff, b_coeff;
  logic [EXP_BITS-1:0]          ld_exp, a_exp, b_exp;
  logic signed [COEFF_BITS:0]   sel_coeff;
  logic [EXP_BITS-1:0]          sel_exp;

  logic a_has, b_has, take_a, take_b, take_both, is_empty, is_last;
  logic finish;

  logic      out_valid_q, out_valid_d;
  out_item_t out_q;

  // ---- loads ----
  assign ld_coeff = COEFF_BITS'(in_data_i.term_coeff);
  assign ld_exp   = EXP_BITS'(in_data_i.term_exponent);
  assign wdata    = {ld_coeff, ld_exp};
  assign we_a     = cmd_i.load_a && (cnt_a_q < FullCnt);
  assign we_b     = cmd_i.load_b && (cnt_b_q < FullCnt);

  // read address follows the next index so data for idx_*_q is ready each cycle
  spma_ram #(.WIDTH(TW), .DEPTH(MAX_TERMS)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (cnt_a_q[AW-1:0]),
    .wdata_i (wdata),
    .raddr_i (idx_a_d[AW-1:0]),
    .rdata_o (rd_a)
  );

  spma_ram #(.WIDTH(TW), .DEPTH(MAX_TERMS)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (cnt_b_q[AW-1:0]),
    .wdata_i (wdata),
    .raddr_i (idx_b_d[AW-1:0]),
    .rdata_o (rd_b)
  );

  // ---- merge selection ----
  assign a_coeff = rd_a[TW-1:EXP_BITS];
  assign a_exp   = rd_a[EXP_BITS-1:0];
  assign b_coeff = rd_b[TW-1:EXP_BITS];
  assign b_exp   = rd_b[EXP_BITS-1:0];

  assign a_has     = idx_a_q < cnt_a_q;
  assign b_has     = idx_b_q < cnt_b_q;
  assign take_both = a_has && b_has && (a_exp == b_exp);
  assign take_a    = a_has && (!b_has || (a_exp > b_exp));
  assign take_b    = b_has && (!a_has || (b_exp > a_exp));
  assign is_empty  = !a_has && !b_has;

  assign idx_a_nx = idx_a_q + CW'(take_a || take_both);
  assign idx_b_nx = idx_b_q + CW'(take_b || take_both);
  assign is_last  = !(idx_a_nx < cnt_a_q) && !(idx_b_nx < cnt_b_q);
  assign finish   = cmd_i.step && is_last;

  always_comb begin
    sel_coeff = '0;
    sel_exp   = '0;
    if (take_both) begin
      sel_coeff = (COEFF_BITS + 1)'(a_coeff) + (COEFF_BITS + 1)'(b_coeff);
      sel_exp   = a_exp;
    end else if (take_a) begin
      sel_coeff = (COEFF_BITS + 1)'(a_coeff);
      sel_exp   = a_exp;
    end else if (take_b) begin
      sel_coeff = (COEFF_BITS + 1)'(b_coeff);
      sel_exp   = b_exp;
    end
  end

  // ---- state update ----
  always_comb begin
    cnt_a_d = cnt_a_q;
    cnt_b_d = cnt_b_q;
    ovf_d   = ovf_q;
    idx_a_d = idx_a_q;
    idx_b_d = idx_b_q;
    if (we_a) cnt_a_d = cnt_a_q + CW'(1);
    if (we_b) cnt_b_d = cnt_b_q + CW'(1);
    if ((cmd_i.load_a && !we_a) || (cmd_i.load_b && !we_b)) ovf_d = 1'b1;
    if (cmd_i.step) begin
      idx_a_d = idx_a_nx;
      idx_b_d = idx_b_nx;
    end
    if (finish) begin
      cnt_a_d = '0;
      cnt_b_d = '0;
      ovf_d   = 1'b0;
      idx_a_d = '0;
      idx_b_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      ovf_q   <= 1'b0;
      idx_a_q <= '0;
      idx_b_q <= '0;
    end else begin
      cnt_a_q <= cnt_a_d;
      cnt_b_q <= cnt_b_d;
      ovf_q   <= ovf_d;
      idx_a_q <= idx_a_d;
      idx_b_q <= idx_b_d;
    end
  end

  // ---- output register ----
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.last     = is_last;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      out_q.sum_coeff     <= OutCoeffW'(sel_coeff);
      out_q.sum_exponent  <= OutExpW'(sel_exp);
      out_q.from_both     <= take_both;
      out_q.empty_result  <= is_empty;
      out_q.dropped_terms <= ovf_q;
      out_q.last_term     <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---- checks ----
  `SPMA_ASSERT(a_step_needs_slot, clk_i, rst_ni, cmd_i.step |-> sts_o.out_free)
  `SPMA_ASSERT(a_finish_clears, clk_i, rst_ni,
      finish |=> (cnt_a_q == '0) && (cnt_b_q == '0) && !ovf_q)
  `SPMA_ASSERT(a_term_in_range, clk_i, rst_ni,
      (cmd_i.step && !is_empty) |-> (take_a || take_b || take_both))
  `SPMA_ASSERT(a_cnt_bounded, clk_i, rst_ni,
      (cnt_a_q <= FullCnt) && (cnt_b_q <= FullCnt))

endmodule
